### sv/aeut_pkg.sv
// Shared types and constants of the escape/UTF-8 tokenizer.
package aeut_pkg;

    localparam int MaxParams  = 32;
    localparam int ParamBytes = 255;
    localparam int InterBytes = 15;
    localparam int OscBytes   = 511;

    localparam logic [2:0] KIND_PRINT = 3'd0;
    localparam logic [2:0] KIND_CTRL  = 3'd1;
    localparam logic [2:0] KIND_ESC   = 3'd2;
    localparam logic [2:0] KIND_CSI   = 3'd3;
    localparam logic [2:0] KIND_OSCD  = 3'd4;
    localparam logic [2:0] KIND_OSCE  = 3'd5;

    // One classified request handed from the front to the back.
    // A CSI dispatch travels as one entry; the back expands it into a run.
    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] code_point;
        logic [6:0]  final_byte;
        logic [6:0]  prefix_byte;
        logic [3:0]  inter_count;
        logic [5:0]  total;
        logic [5:0]  stored;
        logic [23:0] tail_value;
        logic [16:0] osc_number;
    } aeut_evt_t;

    // One parameter store write.
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [23:0] data;
    } aeut_pwr_t;

endpackage

### sv/aeut_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aeut_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/aeut_front.sv
// Front end: UTF-8 decode, escape state machine, parameter collection.
module aeut_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          byte_in,
    output logic                emit,
    output aeut_pkg::aeut_evt_t evt,
    output aeut_pkg::aeut_pwr_t pwr
);
    import aeut_pkg::*;

    localparam logic [3:0] ST_GROUND    = 4'd0;
    localparam logic [3:0] ST_ESC       = 4'd1;
    localparam logic [3:0] ST_ESC_IMD   = 4'd2;
    localparam logic [3:0] ST_CSI_START = 4'd3;
    localparam logic [3:0] ST_CSI_ARGS  = 4'd4;
    localparam logic [3:0] ST_CSI_IMD   = 4'd5;
    localparam logic [3:0] ST_CSI_SKIP  = 4'd6;
    localparam logic [3:0] ST_OSC       = 4'd7;
    localparam logic [3:0] ST_STRING    = 4'd8;

    localparam logic [23:0] PvalMax = 24'd9999999;
    localparam logic [16:0] OscMax  = 17'd65535;
    localparam logic [16:0] OscNone = '1;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  urem_reg, urem_next;
    logic [20:0] uacc_reg, uacc_next;
    logic [5:0]  pstored_reg, pstored_next;
    logic [23:0] pacc_reg, pacc_next;
    logic        phas_reg, phas_next;
    logic [7:0]  pbytes_reg, pbytes_next;
    logic [6:0]  prefix_reg, prefix_next;
    logic [3:0]  inter_reg, inter_next;
    logic [16:0] oscv_reg, oscv_next;
    logic        osep_reg, osep_next;
    logic [8:0]  obytes_reg, obytes_next;

    logic        is_param, is_inter, is_final, is_ctl, is_digit;
    logic [27:0] pmul;
    logic [20:0] omul;
    logic [5:0]  csi_total;
    logic [20:0] uacc_shift;
    logic [16:0] osc_base;

    assign is_param = byte_in >= 8'h30 && byte_in <= 8'h3F;
    assign is_inter = byte_in >= 8'h20 && byte_in <= 8'h2F;
    assign is_final = byte_in >= 8'h40 && byte_in <= 8'h7E;
    assign is_ctl   = byte_in < 8'h20 || byte_in == 8'h7F;
    assign is_digit = byte_in >= 8'h30 && byte_in <= 8'h39;
    assign pmul = {4'd0, pacc_reg} * 28'd10 + {24'd0, byte_in[3:0]};
    assign osc_base = oscv_reg[16] ? 17'd0 : oscv_reg;
    assign omul = {4'd0, osc_base} * 21'd10 + {17'd0, byte_in[3:0]};
    assign uacc_shift = {uacc_reg[14:0], byte_in[5:0]};
    assign csi_total = pstored_reg
                     + (((phas_reg || pstored_reg != 6'd0)
                         && pstored_reg < 6'(MaxParams)) ? 6'd1 : 6'd0);

    always_comb
    begin
        logic handle;
        state_next  = state_reg;
        urem_next   = urem_reg;
        uacc_next   = uacc_reg;
        pstored_next = pstored_reg;
        pacc_next   = pacc_reg;
        phas_next   = phas_reg;
        pbytes_next = pbytes_reg;
        prefix_next = prefix_reg;
        inter_next  = inter_reg;
        oscv_next   = oscv_reg;
        osep_next   = osep_reg;
        obytes_next = obytes_reg;
        emit = 1'b0;
        evt  = '0;
        evt.osc_number = OscNone;
        pwr  = '0;
        handle = 1'b1;

        // UTF-8 layer in front of the escape parser.
        if (state_reg == ST_GROUND && byte_in >= 8'hC0 && byte_in < 8'hFE)
        begin
            handle = 1'b0;
            if (byte_in >= 8'hC2 && byte_in < 8'hE0)
            begin
                uacc_next = {16'd0, byte_in[4:0]};
                urem_next = 2'd1;
            end
            else if (byte_in >= 8'hE0 && byte_in < 8'hF0)
            begin
                uacc_next = {17'd0, byte_in[3:0]};
                urem_next = 2'd2;
            end
            else if (byte_in >= 8'hF0 && byte_in < 8'hF8)
            begin
                uacc_next = {18'd0, byte_in[2:0]};
                urem_next = 2'd3;
            end
        end
        else if (state_reg == ST_GROUND && urem_reg == 2'd0
                 && byte_in >= 8'hA0 && byte_in < 8'hC0)
        begin
            handle = 1'b0;
        end
        else if (urem_reg != 2'd0)
        begin
            if (byte_in[7:6] == 2'b10)
            begin
                handle = 1'b0;
                uacc_next = uacc_shift;
                urem_next = urem_reg - 2'd1;
                if (urem_reg == 2'd1 && state_reg == ST_GROUND
                    && uacc_shift <= 21'h10FFFF)
                begin
                    emit = 1'b1;
                    evt.kind = KIND_PRINT;
                    evt.code_point = uacc_shift;
                end
            end
            else
            begin
                urem_next = 2'd0;
            end
        end

        if (handle)
        begin
            if (byte_in == 8'h18 || byte_in == 8'h1A)
            begin
                state_next = ST_GROUND;
            end
            else if (byte_in == 8'h1B)
            begin
                if (state_reg == ST_OSC)
                begin
                    emit = 1'b1;
                    evt.kind = KIND_OSCE;
                    evt.osc_number = oscv_reg;
                    oscv_next = OscNone;
                    obytes_next = '0;
                    osep_next = 1'b0;
                end
                state_next = ST_ESC;
                pstored_next = '0; pacc_next = '0; phas_next = 1'b0;
                pbytes_next = '0; prefix_next = '0; inter_next = '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_GROUND:
                    begin
                        if (byte_in < 8'h20)
                        begin
                            emit = 1'b1;
                            evt.kind = KIND_CTRL;
                            evt.code_point = {13'd0, byte_in};
                        end
                        else if (byte_in != 8'h7F)
                        begin
                            emit = 1'b1;
                            evt.kind = KIND_PRINT;
                            evt.code_point = {13'd0, byte_in};
                        end
                    end
                    ST_ESC:
                    begin
                        if (is_inter)
                        begin
                            if (inter_reg < 4'(InterBytes)) inter_next = inter_reg + 4'd1;
                            state_next = ST_ESC_IMD;
                        end
                        else if (byte_in >= 8'h30 && byte_in <= 8'h7E)
                        begin
                            if (byte_in == 8'h5B)
                            begin
                                state_next = ST_CSI_START;
                                pstored_next = '0; pacc_next = '0; phas_next = 1'b0;
                                pbytes_next = '0; prefix_next = '0; inter_next = '0;
                            end
                            else if (byte_in == 8'h5D)
                            begin
                                state_next = ST_OSC;
                                oscv_next = OscNone;
                                obytes_next = '0;
                                osep_next = 1'b0;
                            end
                            else if (byte_in == 8'h50)
                            begin
                                state_next = ST_STRING;
                                pstored_next = '0; pacc_next = '0; phas_next = 1'b0;
                                pbytes_next = '0; prefix_next = '0; inter_next = '0;
                            end
                            else if (byte_in == 8'h58 || byte_in == 8'h5E
                                     || byte_in == 8'h5F)
                            begin
                                state_next = ST_STRING;
                            end
                            else
                            begin
                                state_next = ST_GROUND;
                                emit = 1'b1;
                                evt.kind = KIND_ESC;
                                evt.final_byte = byte_in[6:0];
                                evt.inter_count = inter_reg;
                            end
                        end
                        else
                        begin
                            state_next = ST_GROUND;
                            if (byte_in < 8'h20)
                            begin
                                emit = 1'b1;
                                evt.kind = KIND_CTRL;
                                evt.code_point = {13'd0, byte_in};
                            end
                        end
                    end
                    ST_ESC_IMD:
                    begin
                        if (is_inter)
                        begin
                            if (inter_reg < 4'(InterBytes)) inter_next = inter_reg + 4'd1;
                        end
                        else if (byte_in >= 8'h30 && byte_in <= 8'h7E)
                        begin
                            state_next = ST_GROUND;
                            emit = 1'b1;
                            evt.kind = KIND_ESC;
                            evt.final_byte = byte_in[6:0];
                            evt.inter_count = inter_reg;
                        end
                        else
                        begin
                            state_next = ST_GROUND;
                        end
                    end
                    ST_CSI_START, ST_CSI_ARGS:
                    begin
                        if (is_param)
                        begin
                            state_next = ST_CSI_ARGS;
                            if (pbytes_reg < 8'(ParamBytes))
                            begin
                                if (pbytes_reg == 8'd0 && byte_in >= 8'h3C)
                                begin
                                    prefix_next = byte_in[6:0];
                                end
                                pbytes_next = pbytes_reg + 8'd1;
                                if (pstored_reg < 6'(MaxParams))
                                begin
                                    if (is_digit)
                                    begin
                                        pacc_next = (pmul > {4'd0, PvalMax})
                                                  ? PvalMax : pmul[23:0];
                                        phas_next = 1'b1;
                                    end
                                    else if (byte_in == 8'h3B || byte_in == 8'h3A)
                                    begin
                                        pwr.en = 1'b1;
                                        pwr.addr = pstored_reg[4:0];
                                        pwr.data = phas_reg ? pacc_reg : 24'd0;
                                        pstored_next = pstored_reg + 6'd1;
                                        pacc_next = '0;
                                        phas_next = 1'b0;
                                    end
                                end
                            end
                        end
                        else if (is_inter)
                        begin
                            if (inter_reg < 4'(InterBytes)) inter_next = inter_reg + 4'd1;
                            state_next = ST_CSI_IMD;
                        end
                        else if (is_final)
                        begin
                            state_next = ST_GROUND;
                            emit = 1'b1;
                            evt.kind = KIND_CSI;
                            evt.final_byte = byte_in[6:0];
                            evt.prefix_byte = prefix_reg;
                            evt.inter_count = inter_reg;
                            evt.total = csi_total;
                            evt.stored = pstored_reg;
                            evt.tail_value = phas_reg ? pacc_reg : 24'd0;
                        end
                        else if (!is_ctl)
                        begin
                            state_next = ST_CSI_SKIP;
                        end
                    end
                    ST_CSI_IMD:
                    begin
                        if (is_inter)
                        begin
                            if (inter_reg < 4'(InterBytes)) inter_next = inter_reg + 4'd1;
                        end
                        else if (is_final)
                        begin
                            state_next = ST_GROUND;
                            emit = 1'b1;
                            evt.kind = KIND_CSI;
                            evt.final_byte = byte_in[6:0];
                            evt.prefix_byte = (prefix_reg == 7'h3C) ? 7'd0 : prefix_reg;
                            evt.inter_count = inter_reg;
                            evt.total = csi_total;
                            evt.stored = pstored_reg;
                            evt.tail_value = phas_reg ? pacc_reg : 24'd0;
                        end
                        else
                        begin
                            state_next = ST_CSI_SKIP;
                        end
                    end
                    ST_CSI_SKIP:
                    begin
                        if (is_final) state_next = ST_GROUND;
                    end
                    ST_OSC:
                    begin
                        if (byte_in == 8'h07)
                        begin
                            emit = 1'b1;
                            evt.kind = KIND_OSCE;
                            evt.osc_number = oscv_reg;
                            oscv_next = OscNone;
                            obytes_next = '0;
                            osep_next = 1'b0;
                            state_next = ST_GROUND;
                        end
                        else if (!is_ctl)
                        begin
                            if (!osep_reg)
                            begin
                                if (is_digit)
                                begin
                                    oscv_next = (omul > {4'd0, OscMax})
                                              ? OscMax : omul[16:0];
                                end
                                else
                                begin
                                    osep_next = 1'b1;
                                end
                            end
                            else if (obytes_reg < 9'(OscBytes))
                            begin
                                obytes_next = obytes_reg + 9'd1;
                                emit = 1'b1;
                                evt.kind = KIND_OSCD;
                                evt.code_point = {13'd0, byte_in};
                                evt.osc_number = oscv_reg;
                            end
                        end
                    end
                    ST_STRING:
                    begin
                        if (byte_in == 8'h07) state_next = ST_GROUND;
                    end
                    default:
                    begin
                        state_next = ST_GROUND;
                    end
                endcase
            end
        end

        if (!take)
        begin
            emit = 1'b0;
            pwr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_GROUND;
            urem_reg <= '0; uacc_reg <= '0;
            pstored_reg <= '0; pacc_reg <= '0; phas_reg <= 1'b0;
            pbytes_reg <= '0; prefix_reg <= '0; inter_reg <= '0;
            oscv_reg <= OscNone; osep_reg <= 1'b0; obytes_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            urem_reg <= urem_next; uacc_reg <= uacc_next;
            pstored_reg <= pstored_next; pacc_reg <= pacc_next; phas_reg <= phas_next;
            pbytes_reg <= pbytes_next; prefix_reg <= prefix_next; inter_reg <= inter_next;
            oscv_reg <= oscv_next; osep_reg <= osep_next; obytes_reg <= obytes_next;
        end
    end
endmodule

### sv/aeut_back.sv
// Back end: two-entry queue, parameter store and result sequencer.
module aeut_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aeut_pkg::aeut_evt_t push_evt,
    input  aeut_pkg::aeut_pwr_t pwr,
    output logic                full,
    output logic                busy,
    output logic                valid,
    input  logic                stall,
    output logic [2:0]          event_kind,
    output logic [20:0]         code_point,
    output logic [6:0]          final_byte,
    output logic [6:0]          prefix_byte,
    output logic [3:0]          intermediate_count,
    output logic [5:0]          param_total,
    output logic [4:0]          param_position,
    output logic [23:0]         param_value,
    output logic [16:0]         osc_number,
    output logic                last
);
    import aeut_pkg::*;

    // Queue of two requests.
    aeut_evt_t  q_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg, wp_reg;
    aeut_evt_t  head;
    logic       head_v;
    logic       csi_queued;

    // Run sequencer: one slot per result, each read from the store before it is loaded.
    logic       run_reg;
    logic [5:0] pos_reg;
    logic       rd_pend_reg;
    aeut_evt_t  cur_reg;
    logic [4:0] rd_addr;
    logic [23:0] rd_data;

    // Output register.
    logic        ov_reg;
    logic [2:0]  kind_reg;
    logic [20:0] cp_reg;
    logic [6:0]  fin_reg;
    logic [6:0]  pre_reg;
    logic [3:0]  ic_reg;
    logic [5:0]  tot_reg;
    logic [4:0]  opos_reg;
    logic [23:0] val_reg;
    logic [16:0] osc_reg;
    logic        last_reg;
    logic        ofree;
    logic        pop;
    logic        fire;
    logic        start_run;
    logic        load_simple;
    logic        load_run;

    assign head   = q_reg[rp_reg];
    assign head_v = cnt_reg != 2'd0;
    assign full   = cnt_reg == 2'd2;
    assign ofree  = !ov_reg || !stall;
    // A queued dispatch still has to read the store, so it counts as busy.
    assign csi_queued = (cnt_reg != 2'd0 && q_reg[rp_reg].kind == KIND_CSI
                         && q_reg[rp_reg].total != 6'd0)
                     || (cnt_reg == 2'd2 && q_reg[~rp_reg].kind == KIND_CSI
                         && q_reg[~rp_reg].total != 6'd0);
    assign busy   = run_reg || rd_pend_reg || csi_queued;
    assign valid  = ov_reg;

    assign event_kind         = kind_reg;
    assign code_point         = cp_reg;
    assign final_byte         = fin_reg;
    assign prefix_byte        = pre_reg;
    assign intermediate_count = ic_reg;
    assign param_total        = tot_reg;
    assign param_position     = opos_reg;
    assign param_value        = val_reg;
    assign osc_number         = osc_reg;
    assign last               = last_reg;

    aeut_ram #(.Width(24), .Depth(MaxParams)) u_store (
        .clk     (clk),
        .wr_en   (pwr.en),
        .wr_addr (pwr.addr),
        .wr_data (pwr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pop the head when it is simple, or start a CSI run from it.
    assign pop = head_v && !run_reg && !rd_pend_reg && ofree;
    assign start_run = head.kind == KIND_CSI && head.total != 6'd0;
    assign load_simple = pop && !start_run;
    // Issue a read for the current run position; data lands next cycle.
    assign fire = run_reg && !rd_pend_reg;
    assign load_run = rd_pend_reg && ofree;
    assign rd_addr = pos_reg[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= '0; q_reg[1] <= '0;
            cnt_reg <= '0; rp_reg <= 1'b0; wp_reg <= 1'b0;
            run_reg <= 1'b0; pos_reg <= '0; rd_pend_reg <= 1'b0; ov_reg <= 1'b0;
            cur_reg <= '0;
            kind_reg <= '0; cp_reg <= '0; fin_reg <= '0; pre_reg <= '0;
            ic_reg <= '0; tot_reg <= '0; opos_reg <= '0; val_reg <= '0;
            osc_reg <= '0; last_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wp_reg] <= push_evt;
                wp_reg <= ~wp_reg;
            end
            cnt_reg <= cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
            if (pop) rp_reg <= ~rp_reg;

            if (load_simple || load_run)
            begin
                ov_reg <= 1'b1;
            end
            else if (!stall)
            begin
                ov_reg <= 1'b0;
            end

            if (pop)
            begin
                if (start_run)
                begin
                    run_reg <= 1'b1;
                    pos_reg <= '0;
                    cur_reg <= head;
                end
                else
                begin
                    kind_reg <= head.kind;
                    cp_reg <= head.code_point;
                    fin_reg <= head.final_byte;
                    pre_reg <= head.prefix_byte;
                    ic_reg <= head.inter_count;
                    tot_reg <= head.total;
                    opos_reg <= '0;
                    val_reg <= '0;
                    osc_reg <= head.osc_number;
                    last_reg <= 1'b1;
                end
            end
            else if (fire)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (load_run)
            begin
                rd_pend_reg <= 1'b0;
                kind_reg <= KIND_CSI;
                cp_reg <= '0;
                fin_reg <= cur_reg.final_byte;
                pre_reg <= cur_reg.prefix_byte;
                ic_reg <= cur_reg.inter_count;
                tot_reg <= cur_reg.total;
                opos_reg <= pos_reg[4:0];
                val_reg <= (pos_reg < cur_reg.stored) ? rd_data : cur_reg.tail_value;
                osc_reg <= '1;
                last_reg <= (pos_reg + 6'd1 == cur_reg.total);
                if (pos_reg + 6'd1 == cur_reg.total)
                begin
                    run_reg <= 1'b0;
                end
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end
endmodule

### sv/ansi_escape_utf8_tokenizer.sv
// Top level of the terminal byte-stream tokenizer.
//
// Usage: raw terminal output bytes arrive on byte_in under valid/stall;
// one request is taken per cycle while stall is low. Each byte gives zero
// or one event, except a CSI final byte, which gives a run of one result
// per parameter (up to 32; one event if it has none), last marking the end of the run.
// Channels: input valid/stall with byte_in; output valid_out/stall_out
// (stall_out driven by the receiver) carrying every event field.
// Path: an event is registered in the queue, then in the output register.
// Throughput: one byte per cycle for print, control, ESC and OSC traffic
// while stall is low. After its final byte, a CSI dispatch holds the input
// while it leaves the queue, then reads and loads each parameter in turn,
// since each read waits on the registered store port.
// Reset: asynchronous, active low; parser in the normal state, UTF-8
// decode idle, queue and output register empty. The parameter store is
// not cleared; only entries written by the current sequence are read.
// Receiver stall: the output register holds; the queue absorbs two more
// requests, then stall rises back to the sender.
module ansi_escape_utf8_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [7:0]  byte_in,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [2:0]  event_kind,
    output logic [20:0] code_point,
    output logic [6:0]  final_byte,
    output logic [6:0]  prefix_byte,
    output logic [3:0]  intermediate_count,
    output logic [5:0]  param_total,
    output logic [4:0]  param_position,
    output logic [23:0] param_value,
    output logic [16:0] osc_number,
    output logic        last
);
    import aeut_pkg::*;

    logic      take;
    logic      emit;
    logic      full;
    logic      busy;
    aeut_evt_t evt;
    aeut_pwr_t pwr;

    // Hold input while the queue is full, and while a CSI dispatch waits in
    // the queue or reads the store, so that a new parameter write cannot
    // overtake it.
    assign stall = full || busy;
    assign take  = valid && !stall;

    aeut_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (byte_in),
        .emit    (emit),
        .evt     (evt),
        .pwr     (pwr)
    );

    aeut_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (emit),
        .push_evt           (evt),
        .pwr                (pwr),
        .full               (full),
        .busy               (busy),
        .valid              (valid_out),
        .stall              (stall_out),
        .event_kind         (event_kind),
        .code_point         (code_point),
        .final_byte         (final_byte),
        .prefix_byte        (prefix_byte),
        .intermediate_count (intermediate_count),
        .param_total        (param_total),
        .param_position     (param_position),
        .param_value        (param_value),
        .osc_number         (osc_number),
        .last               (last)
    );

    // Kinds above OSC end are never produced.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> event_kind <= KIND_OSCE)
        else $error("event kind out of range");

    // Every non-CSI event closes its own run.
    a_last_simple: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && event_kind != KIND_CSI |-> last)
        else $error("simple event without last");

    // A CSI result with a nonzero total never carries a position at or past its total.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && event_kind == KIND_CSI && param_total != 6'd0
        |-> {1'b0, param_position} < param_total)
        else $error("parameter position beyond total");
endmodule
